@@ sv/key_matrix_press_detector_macros.svh @@
// assertion macros used by the rtl
`ifndef KEY_MATRIX_PRESS_DETECTOR_MACROS_SVH
`define KEY_MATRIX_PRESS_DETECTOR_MACROS_SVH

// same-cycle implication
`define KMPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KMPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/kmpd_pkg.sv @@
package kmpd_pkg;

   localparam int MatrixRows = 8;
   localparam int MatrixCols = 8;
   localparam int KeyCount   = MatrixRows * MatrixCols;
   localparam int IndexWidth = $clog2(KeyCount);
   localparam int CodeWidth  = 7;

   typedef logic [MatrixCols-1:0] row_type;
   typedef logic [KeyCount-1:0]   key_bits_type;
   typedef logic [CodeWidth-1:0]  code_type;

   typedef struct packed {
      logic     valid;
      code_type key_code;
      logic     shift_held;
      logic     ctrl_held;
      logic     last_of_scan;
   } kmpd_result_type;

endpackage

@@ sv/kmpd_walker.sv @@
`include "key_matrix_press_detector_macros.svh"

module kmpd_walker
   import kmpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  key_bits_type    load_bits,
   input  logic            load_shift,
   input  logic            load_ctrl,
   input  logic            take,
   output logic            busy,
   output kmpd_result_type result
);

   key_bits_type          bits_ff, bits_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic                  shift_ff, shift_in;
   logic                  ctrl_ff, ctrl_in;
   logic                  emit;
   logic                  advance;
   logic                  last;

   assign busy    = |bits_ff;
   assign emit    = bits_ff[0] && take;
   assign advance = busy && (!bits_ff[0] || take);
   assign last    = ~|bits_ff[KeyCount-1:1];

   always_comb begin
      bits_in  = bits_ff;
      idx_in   = idx_ff;
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      if (load) begin
         bits_in  = load_bits;
         idx_in   = '0;
         shift_in = load_shift;
         ctrl_in  = load_ctrl;
      end else if (advance) begin
         bits_in = bits_ff >> 1;
         idx_in  = idx_ff + IndexWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         idx_ff  <= '0;
      end else begin
         bits_ff <= bits_in;
         idx_ff  <= idx_in;
      end
      shift_ff <= shift_in;
      ctrl_ff  <= ctrl_in;
   end

   always_comb begin
      result.valid        = emit;
      result.key_code     = CodeWidth'(idx_ff) + CodeWidth'(1);
      result.shift_held   = shift_ff;
      result.ctrl_held    = ctrl_ff;
      result.last_of_scan = last;
   end

   `KMPD_ASSERT_NEXT(a_load_starts_at_zero, load, idx_ff == '0, "walk did not restart at key zero")
   `KMPD_ASSERT_NEXT(a_last_ends_walk, emit && last, !busy, "walk still busy after last word")
   `KMPD_ASSERT_NEXT(a_idle_bit_skips, busy && !bits_ff[0] && !load, idx_ff == $past(idx_ff) + IndexWidth'(1), "index did not step past an idle key")

endmodule

@@ sv/key_matrix_press_detector.sv @@
// Reports newly pressed keys of an 8x8 active-low key matrix. Each req word
// is a full scan of eight row bytes; every key that is low now and was high
// in the previous scan produces one rsp word with key code 1 + row*8 + column,
// row 0 column 0 first, the shift and ctrl flags of this scan, and
// last_of_scan set on the final word of the scan. Releases and unchanged
// scans produce nothing. After reset the previous scan reads as all keys
// held. A scan is walked by a shift register one key bit per cycle, unless
// rsp is stalled, and each rsp word is registered and shows up in the cycle
// after its key is walked. req_stall stays high for the walk, which runs key
// by key up to the highest newly pressed one (at most 64 keys) and holds
// through any stall on rsp. A scan with no new press does not raise
// req_stall. ROWS and COLUMNS mask out unused rows and columns from reporting.
module key_matrix_press_detector
   import kmpd_pkg::*;
#(
   parameter int ROWS    = 8,
   parameter int COLUMNS = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  row_type        req_row_0,
   input  row_type        req_row_1,
   input  row_type        req_row_2,
   input  row_type        req_row_3,
   input  row_type        req_row_4,
   input  row_type        req_row_5,
   input  row_type        req_row_6,
   input  row_type        req_row_7,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output code_type       rsp_key_code,
   output logic           rsp_shift_held,
   output logic           rsp_ctrl_held,
   output logic           rsp_last_of_scan
);

   row_type         now [MatrixRows];
   row_type         prev_ff [MatrixRows];
   key_bits_type    pressed;
   logic            accept;
   logic            busy;
   logic            take;
   kmpd_result_type result;
   logic            rsp_valid_ff;
   code_type        key_code_ff;
   logic            shift_ff;
   logic            ctrl_ff;
   logic            last_ff;

   assign now[0] = req_row_0;
   assign now[1] = req_row_1;
   assign now[2] = req_row_2;
   assign now[3] = req_row_3;
   assign now[4] = req_row_4;
   assign now[5] = req_row_5;
   assign now[6] = req_row_6;
   assign now[7] = req_row_7;

   assign req_stall = busy || reset;
   assign accept    = req_valid && !req_stall;
   assign take      = !rsp_valid_ff || !rsp_stall;

   // new press: was high, now low, inside the reported area
   for (genvar r = 0; r < MatrixRows; r++) begin : g_row
      for (genvar c = 0; c < MatrixCols; c++) begin : g_col
         if (r < ROWS && c < COLUMNS) begin : g_on
            assign pressed[r*MatrixCols+c] = prev_ff[r][c] && !now[r][c];
         end else begin : g_off
            assign pressed[r*MatrixCols+c] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MatrixRows; r++) begin
            prev_ff[r] <= '0;
         end
      end else if (accept) begin
         for (int r = 0; r < MatrixRows; r++) begin
            prev_ff[r] <= now[r];
         end
      end
   end

   kmpd_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_bits  (pressed),
      .load_shift (!req_row_3[0] || !req_row_5[6]),
      .load_ctrl  (!req_row_2[0]),
      .take       (take),
      .busy       (busy),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid) begin
         key_code_ff <= result.key_code;
         shift_ff    <= result.shift_held;
         ctrl_ff     <= result.ctrl_held;
         last_ff     <= result.last_of_scan;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_code_ff;
   assign rsp_shift_held   = shift_ff;
   assign rsp_ctrl_held    = ctrl_ff;
   assign rsp_last_of_scan = last_ff;

endmodule
